@@ rtl/packet_payload_signature_classifier_core_defines.svh @@
// Assertion macros for the payload signature classifier.
// Used by the port checker; depends on nothing else.
`ifndef PACKET_PAYLOAD_SIGNATURE_CLASSIFIER_CORE_DEFINES_SVH
`define PACKET_PAYLOAD_SIGNATURE_CLASSIFIER_CORE_DEFINES_SVH

// Property that must hold in the same cycle as its antecedent.
`define PPSC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Property that must hold in the cycle after its antecedent.
`define PPSC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/ppsc_pkg.sv @@
// Shared types and constants of the payload signature classifier.
// Used by the rule cell, the top level and the port checker; no dependencies.
package ppsc_pkg;

   // Fixed field widths.
   localparam int SLOT_W   = 5;
   localparam int OFF_W    = 10;
   localparam int LEN_W    = 5;
   localparam int MAGIC_W  = 64;
   localparam int ID_W     = 8;

   // Request operation codes.
   localparam logic [1:0] OP_CLEAR = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_BYTE  = 2'd2;

   // IP protocol numbers that a rule can name.
   localparam logic [7:0] PROTO_TCP = 8'd6;
   localparam logic [7:0] PROTO_UDP = 8'd17;

   // Protocol class stored with each rule.
   typedef enum logic [1:0] {
      MODE_TCP,
      MODE_UDP,
      MODE_ANY
   } ppsc_mode_type;

   // One request.
   typedef struct packed {
      logic [1:0]          operation;
      logic [SLOT_W-1:0]   rule_slot;
      logic [7:0]          ip_protocol;
      logic [15:0]         flow_port;
      logic [OFF_W-1:0]    magic_offset;
      logic [MAGIC_W-1:0]  magic_low;
      logic [MAGIC_W-1:0]  magic_high;
      logic [LEN_W-1:0]    magic_count;
      logic [ID_W-1:0]     app_id;
      logic [ID_W-1:0]     category_id;
      logic [7:0]          payload_byte;
      logic                last_byte;
   } ppsc_req_type;

   // One classification result.
   typedef struct packed {
      logic                match_found;
      logic [SLOT_W-1:0]   winning_slot;
      logic [ID_W-1:0]     matched_app;
      logic [ID_W-1:0]     matched_category;
   } ppsc_rsp_type;

   // Broadcast controls from the top level to every cell.
   typedef struct packed {
      logic clear;
      logic write;
      logic byte_en;
      logic first;
      logic last;
   } ppsc_ctrl_type;

   // Winner candidate handed from cell to cell during the result sweep.
   typedef struct packed {
      logic                go;
      logic                found;
      logic [SLOT_W-1:0]   slot;
      logic [ID_W-1:0]     app;
      logic [ID_W-1:0]     category;
   } ppsc_cand_type;

endpackage

@@ rtl/ppsc_cell.sv @@
// One rule slot of the classifier: stored rule, per-packet alive flag and
// one stage of the winner sweep. Depends on ppsc_pkg.
module ppsc_cell #(
   parameter int INDEX         = 0,
   parameter int OFFSET_WINDOW = 1024,
   parameter int MAGIC_BYTES   = 16,
   parameter int POS_W         = 11
) (
   input  logic                   clock,
   input  logic                   reset,
   input  ppsc_pkg::ppsc_ctrl_type ctrl,
   input  ppsc_pkg::ppsc_req_type  req,
   input  logic [POS_W-1:0]       pos,
   input  ppsc_pkg::ppsc_cand_type cand_in,
   output ppsc_pkg::ppsc_cand_type cand_out
);

   localparam int IDX_W = (MAGIC_BYTES > 1) ? $clog2(MAGIC_BYTES) : 1;
   localparam int CMP_W = ((POS_W > ppsc_pkg::OFF_W + 1) ? POS_W : ppsc_pkg::OFF_W + 1) + 1;
   localparam logic [CMP_W-1:0] WINDOW = CMP_W'(OFFSET_WINDOW);
   localparam bit REACHABLE = INDEX < (2 ** ppsc_pkg::SLOT_W);
   localparam logic [ppsc_pkg::SLOT_W-1:0] MY_SLOT = ppsc_pkg::SLOT_W'(INDEX);
   localparam logic [ppsc_pkg::LEN_W-1:0] LEN_MAX = ppsc_pkg::LEN_W'(MAGIC_BYTES);

   logic                           valid_ff, valid_in;
   logic                           alive_ff, alive_in;
   ppsc_pkg::ppsc_mode_type        mode_ff;
   logic [15:0]                    port_ff;
   logic [ppsc_pkg::OFF_W-1:0]     offset_ff;
   logic [MAGIC_BYTES-1:0][7:0]    magic_ff;
   logic [ppsc_pkg::LEN_W-1:0]     len_ff;
   logic [ppsc_pkg::ID_W-1:0]      app_ff;
   logic [ppsc_pkg::ID_W-1:0]      category_ff;
   ppsc_pkg::ppsc_cand_type        cand_ff, cand_in_val;

   logic                           write_hit;
   logic [ppsc_pkg::LEN_W-1:0]     len_sat;
   ppsc_pkg::ppsc_mode_type        mode_new;
   logic [2*ppsc_pkg::MAGIC_W-1:0] magic_all;
   logic                           proto_ok, port_ok, has_magic, window_ok, rule_ok;
   logic [CMP_W-1:0]               off_ext, end_ext, pos_ext, rel;
   logic [IDX_W-1:0]               idx;
   logic                           base, in_range, mismatch, kept, fits;

   // Decode a rule write aimed at this slot.
   always_comb begin
      write_hit = REACHABLE && ctrl.write && (req.rule_slot == MY_SLOT);
      len_sat   = (req.magic_count > LEN_MAX) ? LEN_MAX : req.magic_count;
      magic_all = {req.magic_high, req.magic_low};
      priority if (req.ip_protocol == ppsc_pkg::PROTO_TCP) begin
         mode_new = ppsc_pkg::MODE_TCP;
      end else if (req.ip_protocol == ppsc_pkg::PROTO_UDP) begin
         mode_new = ppsc_pkg::MODE_UDP;
      end else begin
         mode_new = ppsc_pkg::MODE_ANY;
      end
   end

   // Header match, evaluated on the first byte of a packet.
   always_comb begin
      unique case (mode_ff)
         ppsc_pkg::MODE_TCP: proto_ok = (req.ip_protocol == ppsc_pkg::PROTO_TCP);
         ppsc_pkg::MODE_UDP: proto_ok = (req.ip_protocol == ppsc_pkg::PROTO_UDP);
         default:            proto_ok = 1'b1;
      endcase
      port_ok   = (port_ff == 16'd0) || (port_ff == req.flow_port);
      has_magic = (len_ff != '0);
      off_ext   = CMP_W'(offset_ff);
      end_ext   = off_ext + CMP_W'(len_ff);
      pos_ext   = CMP_W'(pos);
      window_ok = !(has_magic && (off_ext >= WINDOW));
      rule_ok   = valid_ff && proto_ok && port_ok && window_ok;
   end

   // Magic byte check for the current payload position.
   always_comb begin
      base     = ctrl.first ? rule_ok : alive_ff;
      in_range = (pos_ext >= off_ext) && (pos_ext < end_ext);
      rel      = pos_ext - off_ext;
      idx      = rel[IDX_W-1:0];
      mismatch = in_range && (magic_ff[idx] != req.payload_byte);
      kept     = base && !mismatch;
      // On the last byte the whole magic must lie inside the payload.
      fits     = !has_magic || (end_ext <= pos_ext + CMP_W'(1));
   end

   // Next values of the valid and alive flags.
   always_comb begin
      valid_in = valid_ff;
      alive_in = alive_ff;
      priority if (ctrl.clear) begin
         valid_in = 1'b0;
         alive_in = 1'b0;
      end else if (write_hit) begin
         valid_in = 1'b1;
         alive_in = 1'b0;
      end else if (ctrl.byte_en) begin
         alive_in = ctrl.last ? (kept && fits) : kept;
      end
   end

   // Sweep stage: a live rule replaces the candidate from lower slots.
   always_comb begin
      cand_in_val = cand_in;
      if (cand_in.go && alive_ff) begin
         cand_in_val.found    = 1'b1;
         cand_in_val.slot     = MY_SLOT;
         cand_in_val.app      = app_ff;
         cand_in_val.category = category_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         alive_ff <= 1'b0;
         cand_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         alive_ff <= alive_in;
         cand_ff  <= cand_in_val;
      end
   end

   // Rule storage, loaded by a write to this slot.
   always_ff @(posedge clock) begin
      if (write_hit) begin
         mode_ff     <= mode_new;
         port_ff     <= req.flow_port;
         offset_ff   <= req.magic_offset;
         magic_ff    <= magic_all[MAGIC_BYTES*8-1:0];
         len_ff      <= len_sat;
         app_ff      <= req.app_id;
         category_ff <= req.category_id;
      end
   end

   assign cand_out = cand_ff;

endmodule

@@ rtl/packet_payload_signature_classifier_core.sv @@
// Payload signature classifier: rule table, byte matcher and result port.
// Depends on ppsc_pkg and ppsc_cell.
//
// Usage:
//   The req_ channel carries one request per accepted cycle: clear all
//   rules, write one rule into a slot, or one payload byte of a flow.
//   Clear, write and non-final bytes give no result. Every rule slot is
//   a cell that checks the incoming byte against its own magic in the
//   same cycle. After the byte marked last_byte, a candidate walks the
//   row of cells from slot 0 upward, one cell per cycle, so the highest
//   live slot wins. The result is registered on rsp_ when the walk ends;
//   req_stall stays high during the walk. A final byte is also held off
//   while an earlier result is still on rsp_; all other requests keep
//   flowing then. The result stays on rsp_ unchanged while rsp_stall is
//   high. Reset invalidates all rules, closes any open packet and drops a
//   pending result; rule contents are not cleared.
module packet_payload_signature_classifier_core #(
   parameter int RULES         = 32,
   parameter int OFFSET_WINDOW = 1024,
   parameter int MAGIC_BYTES   = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  ppsc_pkg::ppsc_req_type  req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output ppsc_pkg::ppsc_rsp_type  rsp_data
);

   localparam int POS_W = $clog2(2 * OFFSET_WINDOW);
   localparam logic [POS_W-1:0] POS_MAX = POS_W'(2 * OFFSET_WINDOW - 1);

   logic                    open_ff, open_in;
   logic [POS_W-1:0]        pos_ff, pos_in, pos_eff;
   logic                    start_ff, start_in;
   logic                    busy_ff, busy_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   ppsc_pkg::ppsc_rsp_type  rsp_data_ff;
   logic                    accept, sweep_done;
   ppsc_pkg::ppsc_ctrl_type ctrl;
   ppsc_pkg::ppsc_cand_type chain [0:RULES];

   // Request handshake: hold off during a sweep, and hold a final byte
   // while the result register is still occupied.
   assign req_stall = busy_ff
                   || (rsp_valid_ff && (req_data.operation == ppsc_pkg::OP_BYTE)
                       && req_data.last_byte);
   assign accept    = req_valid && !req_stall;

   // Broadcast controls for the cells.
   always_comb begin
      ctrl.clear   = accept && (req_data.operation == ppsc_pkg::OP_CLEAR);
      ctrl.write   = accept && (req_data.operation == ppsc_pkg::OP_WRITE);
      ctrl.byte_en = accept && (req_data.operation == ppsc_pkg::OP_BYTE);
      ctrl.first   = !open_ff;
      ctrl.last    = req_data.last_byte;
      pos_eff      = open_ff ? pos_ff : '0;
   end

   // Packet tracking and saturating byte position.
   always_comb begin
      open_in  = open_ff;
      pos_in   = pos_ff;
      if (ctrl.byte_en) begin
         if (ctrl.last) begin
            open_in = 1'b0;
            pos_in  = '0;
         end else begin
            open_in = 1'b1;
            pos_in  = (pos_eff == POS_MAX) ? pos_eff : pos_eff + POS_W'(1);
         end
      end
      start_in = ctrl.byte_en && ctrl.last;
   end

   // Sweep seed: nothing found yet.
   always_comb begin
      chain[0]    = '0;
      chain[0].go = start_ff;
   end

   // Row of rule cells.
   for (genvar g = 0; g < RULES; g++) begin : g_cell
      ppsc_cell #(
         .INDEX        (g),
         .OFFSET_WINDOW(OFFSET_WINDOW),
         .MAGIC_BYTES  (MAGIC_BYTES),
         .POS_W        (POS_W)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .ctrl    (ctrl),
         .req     (req_data),
         .pos     (pos_eff),
         .cand_in (chain[g]),
         .cand_out(chain[g+1])
      );
   end

   // Busy flag and result register.
   always_comb begin
      sweep_done = chain[RULES].go;
      busy_in    = busy_ff;
      if (start_in) begin
         busy_in = 1'b1;
      end else if (sweep_done) begin
         busy_in = 1'b0;
      end
      rsp_valid_in = sweep_done || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff      <= 1'b0;
         pos_ff       <= '0;
         start_ff     <= 1'b0;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         open_ff      <= open_in;
         pos_ff       <= pos_in;
         start_ff     <= start_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (sweep_done) begin
         rsp_data_ff.match_found      <= chain[RULES].found;
         rsp_data_ff.winning_slot     <= chain[RULES].slot;
         rsp_data_ff.matched_app      <= chain[RULES].app;
         rsp_data_ff.matched_category <= chain[RULES].category;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ rtl/ppsc_checker.sv @@
// Port-level checker for the payload signature classifier, bound to the top.
// Depends on ppsc_pkg and the assertion macro header.
`include "packet_payload_signature_classifier_core_defines.svh"

module ppsc_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_stall,
   input ppsc_pkg::ppsc_req_type  req_data,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input ppsc_pkg::ppsc_rsp_type  rsp_data
);

   logic last_accept;
   logic no_match;
   logic miss_zero;
   logic rsp_held;

   // A final payload byte was taken, or a result reports no match.
   assign last_accept = req_valid && !req_stall && req_data.last_byte
                     && (req_data.operation == ppsc_pkg::OP_BYTE);
   assign no_match    = rsp_valid && !rsp_data.match_found;
   assign miss_zero   = (rsp_data.winning_slot == '0) && (rsp_data.matched_app == '0)
                     && (rsp_data.matched_category == '0);
   assign rsp_held    = rsp_valid && rsp_stall;

   // A stalled result stays offered.
   `PPSC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_held, rsp_valid, "stalled result dropped")

   // The block holds off requests once a packet has ended.
   `PPSC_ASSERT_NEXT(a_busy_after_last, clock, reset, last_accept, req_stall, "taken mid-sweep")

   // A new result only appears at the end of a sweep.
   `PPSC_ASSERT_SAME(a_rsp_src, clock, reset, $rose(rsp_valid), $past(req_stall), "stray result")

   // A miss reports zero slot and ids.
   `PPSC_ASSERT_SAME(a_miss_zero, clock, reset, no_match, miss_zero, "nonzero miss")

endmodule

bind packet_payload_signature_classifier_core ppsc_checker u_ppsc_checker (.*);

@@ tb/ppsc_result_checker.sv @@
// Watches the request and result channels of the payload signature classifier.
// It predicts each classification and compares it with what the block returns.
// Depends on ppsc_pkg.
`timescale 1ns / 1ps

module ppsc_result_checker #(
   parameter int RULES         = 32,
   parameter int OFFSET_WINDOW = 1024,
   parameter int MAGIC_BYTES   = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  ppsc_pkg::ppsc_req_type  req_data,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  ppsc_pkg::ppsc_rsp_type  rsp_data,
   input  logic                   end_of_run,
   output int                     error_count,
   output int                     pending_count,
   output int                     result_count,
   output int                     hit_count
);

   // Rule table as the block should hold it.
   logic [RULES-1:0]             table_valid;
   ppsc_pkg::ppsc_mode_type      mode_tab   [RULES];
   logic [15:0]                  port_tab   [RULES];
   logic [ppsc_pkg::OFF_W-1:0]   offset_tab [RULES];
   logic [ppsc_pkg::MAGIC_W-1:0] low_tab    [RULES];
   logic [ppsc_pkg::MAGIC_W-1:0] high_tab   [RULES];
   logic [ppsc_pkg::LEN_W-1:0]   len_tab    [RULES];
   logic [ppsc_pkg::ID_W-1:0]    app_tab    [RULES];
   logic [ppsc_pkg::ID_W-1:0]    cat_tab    [RULES];

   // State of the packet currently streaming in.
   logic [RULES-1:0]   live;
   bit                 in_packet;
   int unsigned        position;
   logic [7:0]         pkt_proto;
   logic [15:0]        pkt_port;
   bit                 leftover_checked;

   ppsc_pkg::ppsc_rsp_type expected_verdicts [$];

   // Prints one line per mismatch, but only the first few, and counts them all.
   task automatic report_mismatch(input string what);
      if (error_count < 40) $display("%0t ns: mismatch: %s", $time, what);
      error_count++;
   endtask

   // Magic byte i of a rule; byte 0 sits in the low bits of the low word.
   function automatic logic [7:0] magic_at(input int s, input int unsigned i);
      logic [127:0] both;
      both = {high_tab[s], low_tab[s]};
      return both[8*i +: 8];
   endfunction

   // Applies one accepted request to the predicted state.
   task automatic classify_request(input ppsc_pkg::ppsc_req_type r);
      int unsigned            slot;
      int unsigned            total;
      int                     win;
      bit                     ok;
      ppsc_pkg::ppsc_rsp_type verdict;
      case (r.operation)
         ppsc_pkg::OP_CLEAR: begin
            table_valid = '0;
            live = '0;
         end
         ppsc_pkg::OP_WRITE: begin
            slot = r.rule_slot;
            if (slot < RULES) begin
               table_valid[slot] = 1'b1;
               mode_tab[slot] = (r.ip_protocol == ppsc_pkg::PROTO_TCP) ? ppsc_pkg::MODE_TCP :
                                (r.ip_protocol == ppsc_pkg::PROTO_UDP) ? ppsc_pkg::MODE_UDP :
                                                                        ppsc_pkg::MODE_ANY;
               port_tab[slot]   = r.flow_port;
               offset_tab[slot] = r.magic_offset;
               low_tab[slot]    = r.magic_low;
               high_tab[slot]   = r.magic_high;
               len_tab[slot]    = (r.magic_count > MAGIC_BYTES)
                                  ? ppsc_pkg::LEN_W'(MAGIC_BYTES) : r.magic_count;
               app_tab[slot]    = r.app_id;
               cat_tab[slot]    = r.category_id;
               // A rule written mid-packet only takes part from the next packet.
               live[slot] = 1'b0;
            end
         end
         ppsc_pkg::OP_BYTE: begin
            // The first byte latches protocol and port and arms the agreeing rules.
            if (!in_packet) begin
               in_packet = 1'b1;
               position  = 0;
               pkt_proto = r.ip_protocol;
               pkt_port  = r.flow_port;
               for (int s = 0; s < RULES; s++) begin
                  ok = table_valid[s];
                  if (mode_tab[s] == ppsc_pkg::MODE_TCP && pkt_proto != ppsc_pkg::PROTO_TCP)
                     ok = 1'b0;
                  if (mode_tab[s] == ppsc_pkg::MODE_UDP && pkt_proto != ppsc_pkg::PROTO_UDP)
                     ok = 1'b0;
                  if (port_tab[s] != 0 && port_tab[s] != pkt_port) ok = 1'b0;
                  if (len_tab[s] != 0 && offset_tab[s] >= OFFSET_WINDOW) ok = 1'b0;
                  live[s] = ok;
               end
            end
            // Any rule whose magic disagrees with this byte drops out.
            for (int s = 0; s < RULES; s++) begin
               if (live[s] && len_tab[s] != 0 && position >= offset_tab[s] &&
                   position < offset_tab[s] + len_tab[s] &&
                   magic_at(s, position - offset_tab[s]) != r.payload_byte)
                  live[s] = 1'b0;
            end
            if (!r.last_byte) begin
               if (position < 2 * OFFSET_WINDOW - 1) position++;
            end else begin
               // Highest live slot whose magic fits inside the payload wins.
               total = position + 1;
               win = -1;
               for (int s = 0; s < RULES; s++) begin
                  if (live[s] && !(len_tab[s] != 0 && offset_tab[s] + len_tab[s] > total))
                     win = s;
               end
               verdict = '0;
               if (win >= 0) begin
                  verdict.match_found      = 1'b1;
                  verdict.winning_slot     = win[ppsc_pkg::SLOT_W-1:0];
                  verdict.matched_app      = app_tab[win];
                  verdict.matched_category = cat_tab[win];
               end
               expected_verdicts.push_back(verdict);
               in_packet = 1'b0;
               position  = 0;
               live      = '0;
            end
         end
         default: ;
      endcase
   endtask

   // Compares one returned result with the oldest prediction.
   task automatic check_verdict(input ppsc_pkg::ppsc_rsp_type got);
      ppsc_pkg::ppsc_rsp_type want;
      if (expected_verdicts.size() == 0) begin
         report_mismatch($sformatf("result with none expected: found %0b slot %0d",
                                   got.match_found, got.winning_slot));
      end else begin
         want = expected_verdicts.pop_front();
         if (got.match_found !== want.match_found)
            report_mismatch($sformatf("match_found %0b, expected %0b",
                                      got.match_found, want.match_found));
         if (got.winning_slot !== want.winning_slot)
            report_mismatch($sformatf("winning_slot %0d, expected %0d",
                                      got.winning_slot, want.winning_slot));
         if (got.matched_app !== want.matched_app)
            report_mismatch($sformatf("matched_app %0h, expected %0h",
                                      got.matched_app, want.matched_app));
         if (got.matched_category !== want.matched_category)
            report_mismatch($sformatf("matched_category %0h, expected %0h",
                                      got.matched_category, want.matched_category));
         result_count++;
         if (want.match_found) hit_count++;
      end
   endtask

   // Both channels are sampled at the rising edge.
   always @(posedge clock) begin
      if (reset) begin
         table_valid = '0;
         live = '0;
         in_packet = 1'b0;
         position = 0;
         pkt_proto = '0;
         pkt_port = '0;
         leftover_checked = 1'b0;
         expected_verdicts.delete();
         error_count = 0;
         result_count = 0;
         hit_count = 0;
      end else begin
         if (rsp_valid && !rsp_stall) check_verdict(rsp_data);
         if (req_valid && !req_stall) classify_request(req_data);
         if (end_of_run && !leftover_checked) begin
            leftover_checked = 1'b1;
            if (expected_verdicts.size() != 0)
               report_mismatch($sformatf("%0d expected results never arrived",
                                         expected_verdicts.size()));
         end
      end
      pending_count = expected_verdicts.size();
   end

endmodule

@@ tb/testbench.sv @@
// Top of the payload signature classifier testbench: clock, reset, requests and verdict.
// Drives directed and random rule tables and packets into the block.
// Depends on ppsc_pkg, the classifier core and ppsc_result_checker.
`timescale 1ns / 1ps

module testbench;

   localparam int RULES         = 32;
   localparam int OFFSET_WINDOW = 1024;
   localparam int MAGIC_BYTES   = 16;
   localparam int RANDOM_ITEMS  = 1270;
   localparam int CALM_TAIL     = 200;

   // Operation code the block has to ignore.
   localparam logic [1:0] OP_UNUSED = 2'd3;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   ppsc_pkg::ppsc_req_type req_data = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   ppsc_pkg::ppsc_rsp_type rsp_data;
   logic                   end_of_run = 1'b0;

   int error_count, pending_count, result_count, hit_count;
   int sent_count = 0;
   int stall_left = 0;
   bit idling_on  = 1'b0;

   // What the stimulus knows of the rule table, used to build matching payloads.
   ppsc_pkg::ppsc_req_type rule_shadow [RULES];
   logic [RULES-1:0]       shadow_valid = '0;

   packet_payload_signature_classifier_core #(
      .RULES(RULES), .OFFSET_WINDOW(OFFSET_WINDOW), .MAGIC_BYTES(MAGIC_BYTES)
   ) DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   ppsc_result_checker #(
      .RULES(RULES), .OFFSET_WINDOW(OFFSET_WINDOW), .MAGIC_BYTES(MAGIC_BYTES)
   ) result_check (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .end_of_run(end_of_run), .error_count(error_count),
      .pending_count(pending_count), .result_count(result_count),
      .hit_count(hit_count)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Result side stalls in random bursts.
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall = 1'b0;
      end else if (stall_left > 0) begin
         rsp_stall = 1'b1;
         stall_left--;
      end else if (idling_on && $urandom_range(5) == 0) begin
         rsp_stall = 1'b1;
         stall_left = $urandom_range(3);
      end else begin
         rsp_stall = 1'b0;
      end
   end

   function automatic ppsc_pkg::ppsc_req_type random_fields();
      logic [223:0] bits;
      bits = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      return bits[$bits(ppsc_pkg::ppsc_req_type)-1:0];
   endfunction

   function automatic logic [7:0] pick_proto();
      case ($urandom_range(3))
         0: return ppsc_pkg::PROTO_TCP;
         1: return ppsc_pkg::PROTO_UDP;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] pick_port();
      case ($urandom_range(4))
         0: return 16'd80;
         1: return 16'd443;
         2: return 16'd53;
         default: return 16'($urandom);
      endcase
   endfunction

   // Presents one request, with an occasional idle gap first, and waits for acceptance.
   task automatic send(input ppsc_pkg::ppsc_req_type r);
      if (idling_on && $urandom_range(4) == 0) begin
         @(negedge clock);
         req_valid = 1'b0;
         repeat ($urandom_range(3)) @(negedge clock);
      end
      @(negedge clock);
      req_valid = 1'b1;
      req_data  = r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (r.operation != OP_UNUSED) sent_count++;
   endtask

   task automatic write_rule(input int slot, input logic [7:0] proto,
                             input logic [15:0] port,
                             input logic [ppsc_pkg::OFF_W-1:0] offset,
                             input logic [63:0] low, input logic [63:0] high,
                             input logic [ppsc_pkg::LEN_W-1:0] len,
                             input logic [7:0] app, input logic [7:0] cat);
      ppsc_pkg::ppsc_req_type r;
      r = random_fields();
      r.operation    = ppsc_pkg::OP_WRITE;
      r.rule_slot    = slot[ppsc_pkg::SLOT_W-1:0];
      r.ip_protocol  = proto;
      r.flow_port    = port;
      r.magic_offset = offset;
      r.magic_low    = low;
      r.magic_high   = high;
      r.magic_count  = len;
      r.app_id       = app;
      r.category_id  = cat;
      send(r);
      rule_shadow[slot]  = r;
      shadow_valid[slot] = 1'b1;
   endtask

   task automatic clear_rules();
      ppsc_pkg::ppsc_req_type r;
      r = random_fields();
      r.operation = ppsc_pkg::OP_CLEAR;
      send(r);
      shadow_valid = '0;
   endtask

   task automatic send_byte(input logic [7:0] proto, input logic [15:0] port,
                            input logic [7:0] value, input bit last);
      ppsc_pkg::ppsc_req_type r;
      r = random_fields();
      r.operation    = ppsc_pkg::OP_BYTE;
      r.ip_protocol  = proto;
      r.flow_port    = port;
      r.payload_byte = value;
      r.last_byte    = last;
      send(r);
   endtask

   // Random rule; some reuse another rule's magic so that several slots match at once.
   task automatic random_rule_write();
      int unsigned                slot, donor;
      logic [15:0]                port;
      logic [ppsc_pkg::OFF_W-1:0] offset;
      logic [ppsc_pkg::LEN_W-1:0] len;
      logic [63:0]                low, high;
      slot   = $urandom_range(RULES - 1);
      donor  = $urandom_range(RULES - 1);
      port   = ($urandom_range(4) < 2) ? 16'd0 : pick_port();
      offset = ($urandom_range(19) == 0) ? ppsc_pkg::OFF_W'($urandom_range(200))
                                         : ppsc_pkg::OFF_W'($urandom_range(8));
      len    = ($urandom_range(9) == 0) ? ppsc_pkg::LEN_W'($urandom_range(31, 17))
                                        : ppsc_pkg::LEN_W'($urandom_range(16));
      low    = {$urandom, $urandom};
      high   = {$urandom, $urandom};
      if (shadow_valid[donor] && $urandom_range(2) == 0) begin
         offset = rule_shadow[donor].magic_offset;
         low    = rule_shadow[donor].magic_low;
         high   = rule_shadow[donor].magic_high;
         len    = ppsc_pkg::LEN_W'($urandom_range(rule_shadow[donor].magic_count));
      end
      write_rule(slot, pick_proto(), port, offset, low, high, len,
                 8'($urandom), 8'($urandom));
   endtask

   // Streams one packet; later bytes carry junk protocol and port fields,
   // and the table may be changed between bytes.
   task automatic send_packet(input logic [7:0] proto, input logic [15:0] port,
                              input logic [7:0] payload [$], input bit stir_table);
      for (int i = 0; i < payload.size(); i++) begin
         if (stir_table && i != 0 && $urandom_range(49) == 0) begin
            if ($urandom_range(7) == 0) clear_rules();
            else random_rule_write();
         end
         send_byte(i == 0 ? proto : 8'($urandom), i == 0 ? port : 16'($urandom),
                   payload[i], i == payload.size() - 1);
      end
   endtask

   // Builds a packet that satisfies the rule in a slot, sometimes spoiled on purpose.
   task automatic packet_for_rule(input int slot, input int unsigned min_size,
                                  input bit may_spoil);
      ppsc_pkg::ppsc_req_type rule;
      logic [127:0]           magic;
      logic [7:0]             payload [$];
      int unsigned            len, need, size;
      logic [7:0]             proto;
      logic [15:0]            port;
      rule  = rule_shadow[slot];
      magic = {rule.magic_high, rule.magic_low};
      len   = (rule.magic_count > MAGIC_BYTES) ? MAGIC_BYTES : rule.magic_count;
      need  = rule.magic_offset + len;
      size  = ((need > min_size) ? need : min_size) + $urandom_range(6);
      for (int i = 0; i < size; i++) payload.push_back(8'($urandom));
      for (int i = 0; i < len; i++) payload[rule.magic_offset + i] = magic[8*i +: 8];
      if (may_spoil && len != 0) begin
         case ($urandom_range(9))
            0: payload[rule.magic_offset + $urandom_range(len - 1)] ^= 8'h01 << $urandom_range(7);
            1: while (payload.size() > 1 && payload.size() >= need) void'(payload.pop_back());
            default: ;
         endcase
      end
      proto = (rule.ip_protocol == ppsc_pkg::PROTO_TCP || rule.ip_protocol == ppsc_pkg::PROTO_UDP)
              ? rule.ip_protocol : pick_proto();
      port  = (rule.flow_port != 0) ? rule.flow_port : pick_port();
      send_packet(proto, port, payload, may_spoil);
   endtask

   initial begin
      logic [7:0]             payload [$];
      ppsc_pkg::ppsc_req_type r;
      int                     start, slot;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      idling_on = 1'b1;

      // Empty table: nothing can match.
      payload = '{8'hFF};
      send_packet(8'h00, 16'h0000, payload, 1'b0);
      // Catch-all rule at the lowest slot and a TCP rule with two magic bytes at the top.
      write_rule(0, 8'h00, 16'h0000, '0, '0, '0, '0, 8'hFF, 8'h00);
      write_rule(31, ppsc_pkg::PROTO_TCP, 16'hFFFF, '0, 64'hFF00, '0, 5'd2, 8'h00, 8'hFF);
      payload = '{8'h00, 8'hFF};
      send_packet(ppsc_pkg::PROTO_TCP, 16'hFFFF, payload, 1'b0);
      payload = '{8'h00, 8'hFE};
      send_packet(ppsc_pkg::PROTO_TCP, 16'hFFFF, payload, 1'b0);
      // Magic runs past the end of the payload.
      payload = '{8'h00};
      send_packet(ppsc_pkg::PROTO_TCP, 16'hFFFF, payload, 1'b0);
      // Wrong protocol class.
      payload = '{8'h00, 8'hFF};
      send_packet(ppsc_pkg::PROTO_UDP, 16'hFFFF, payload, 1'b0);
      // Unknown operation must be ignored.
      r = random_fields();
      r.operation = OP_UNUSED;
      send(r);
      // A rule rewritten mid-packet sits out the rest of that packet.
      send_byte(ppsc_pkg::PROTO_TCP, 16'hFFFF, 8'h00, 1'b0);
      write_rule(31, ppsc_pkg::PROTO_TCP, 16'hFFFF, '0, 64'hFF00, '0, 5'd2, 8'h00, 8'hFF);
      send_byte(8'h11, 16'h1234, 8'hFF, 1'b1);
      // A clear mid-packet leaves no rule for that packet.
      send_byte(ppsc_pkg::PROTO_TCP, 16'hFFFF, 8'h00, 1'b0);
      clear_rules();
      send_byte(ppsc_pkg::PROTO_TCP, 16'hFFFF, 8'hFF, 1'b1);
      // Overlong magic is cut to the full sixteen bytes.
      write_rule(30, ppsc_pkg::PROTO_UDP, 16'h0000, 10'd40, {$urandom, $urandom},
                 {$urandom, $urandom}, 5'd31, 8'($urandom), 8'($urandom));
      packet_for_rule(30, 1, 1'b0);

      // Random part: mostly packets aimed at live rules, with rewrites, clears and noise.
      start = sent_count;
      while (sent_count - start < RANDOM_ITEMS) begin
         if (sent_count - start >= RANDOM_ITEMS - CALM_TAIL) idling_on = 1'b0;
         else if ($urandom_range(11) == 0) idling_on = !idling_on;
         case ($urandom_range(99)) inside
            [0:19]:  random_rule_write();
            [20:20]: clear_rules();
            [21:23]: begin
               r = random_fields();
               r.operation = OP_UNUSED;
               send(r);
            end
            [24:79]: begin
               slot = $urandom_range(RULES - 1);
               for (int tries = 0; tries < 8 && !shadow_valid[slot]; tries++)
                  slot = $urandom_range(RULES - 1);
               if (shadow_valid[slot]) packet_for_rule(slot, 1, 1'b1);
               else random_rule_write();
            end
            default: begin
               payload.delete();
               repeat ($urandom_range(7) == 0 ? $urandom_range(40, 1) : $urandom_range(12, 1))
                  payload.push_back(8'($urandom));
               send_packet(pick_proto(), pick_port(), payload, 1'b1);
            end
         endcase
      end

      @(negedge clock);
      req_valid = 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (RULES + 8) @(negedge clock);
      end_of_run = 1'b1;
      @(posedge clock);
      @(negedge clock);
      $display("Drove %0d requests through the rule table; checked %0d classifications,",
               sent_count, result_count);
      $display("%0d of them matching a rule.", hit_count);
      if (error_count == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

   // Run limit, far above the slowest correct run.
   initial begin
      #1000000;
      $display("Run limit reached with %0d results outstanding.", pending_count);
      $display("FAILURE");
      $finish;
   end

endmodule
